/* hdl/heatmap_local_peak_finder_top_assert.svh */
// assertion macros for the heatmap local peak finder checker
// no dependencies; included by the checker file
`ifndef HEATMAP_LOCAL_PEAK_FINDER_TOP_ASSERT_SVH
`define HEATMAP_LOCAL_PEAK_FINDER_TOP_ASSERT_SVH

// same-cycle implication, disabled while dis is high
`define HLPF_ASSERT_IMP(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while dis is high
`define HLPF_ASSERT_NXT(lbl, dis, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/hlpf_pkg.sv */
// types and constants of the heatmap local peak finder
// no dependencies; used by every module of the block
package hlpf_pkg;

  localparam int VALUE_BITS = 16;
  localparam int COL_OUT_W  = 10;
  localparam int ROW_W      = 10;
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd2;

  // reset values and limits
  localparam logic [DIM_W-1:0] MAP_WIDTH_RST  = 11'd368;
  localparam logic [DIM_W-1:0] MAP_HEIGHT_RST = 11'd368;
  localparam logic [DIM_W-1:0] MIN_DIM        = 11'd3;
  localparam logic [DIM_W-1:0] MAX_HEIGHT     = 11'd1024;

  typedef logic signed [VALUE_BITS-1:0] value_t;

  // 0.1 in Q1.14, rounded down
  localparam value_t THRESHOLD_RST = 16'sd1638;

  typedef struct packed {
    value_t smoothed_value;
    value_t raw_value;
    logic   frame_start;
  } hlpf_in_t;

  typedef struct packed {
    logic [COL_OUT_W-1:0] peak_column;
    logic [ROW_W-1:0]     peak_row;
    value_t               peak_value;
  } hlpf_out_t;

  // cross window around the candidate pixel
  typedef struct packed {
    value_t center;
    value_t up;
    value_t down;
    value_t left;
    value_t right;
  } hlpf_win_t;

endpackage

/* hdl/hlpf_line_buf.sv */
// row stores of the peak finder: last smoothed row, the one before, last raw row
// depends on hlpf_pkg
module hlpf_line_buf #(
  parameter int MAX_WIDTH = 1024,
  parameter int ADDR_W    = 10
) (
  input  logic              clk,
  input  logic              accept,
  input  logic [ADDR_W-1:0] cur_addr,
  input  logic [ADDR_W-1:0] next_addr,
  input  hlpf_pkg::value_t  wr_smoothed,
  input  hlpf_pkg::value_t  wr_raw,
  output hlpf_pkg::value_t  center,
  output hlpf_pkg::value_t  left,
  output hlpf_pkg::value_t  up,
  output hlpf_pkg::value_t  right,
  output hlpf_pkg::value_t  raw_above
);
  import hlpf_pkg::*;

  value_t prev_mem   [MAX_WIDTH];
  value_t second_mem [MAX_WIDTH];
  value_t raw_mem    [MAX_WIDTH];

  value_t prev_q_r;
  value_t second_q_r;
  value_t raw_q_r;
  value_t center_r;
  value_t left_r;

  // last smoothed row: write this column, prefetch the next column
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_mem[cur_addr] <= wr_smoothed;
      prev_q_r           <= prev_mem[next_addr];
    end
  end

  // row before: old entry out, entry of the last row moves down
  always_ff @(posedge clk) begin
    if (accept) begin
      second_mem[cur_addr] <= prev_q_r;
      second_q_r           <= second_mem[cur_addr];
    end
  end

  // last raw row
  always_ff @(posedge clk) begin
    if (accept) begin
      raw_mem[cur_addr] <= wr_raw;
      raw_q_r           <= raw_mem[cur_addr];
    end
  end

  // the prefetched entry is this beat's centre, the previous centre its left
  always_ff @(posedge clk) begin
    if (accept) begin
      center_r <= prev_q_r;
      left_r   <= center_r;
    end
  end

  assign center    = center_r;
  assign left      = left_r;
  assign up        = second_q_r;
  assign right     = prev_q_r;
  assign raw_above = raw_q_r;

endmodule

/* hdl/hlpf_peak_eval.sv */
// four-neighbour maximum test with threshold
// depends on hlpf_pkg
module hlpf_peak_eval (
  input  hlpf_pkg::hlpf_win_t win,
  input  hlpf_pkg::value_t    threshold,
  input  logic                in_window,
  output logic                is_peak
);
  import hlpf_pkg::*;

  // strict compares against all four neighbours and the threshold
  always_comb begin
    is_peak = in_window &&
              (win.center > win.up) && (win.center > win.down) &&
              (win.center > win.left) && (win.center > win.right) &&
              (win.center > threshold);
  end

endmodule

/* hdl/heatmap_local_peak_finder_top.sv */
// heatmap local peak finder: position counters, window stage, result register
// depends on hlpf_pkg, hlpf_line_buf, hlpf_peak_eval
//
// Usage: pixels enter in raster order on in_valid/in_stall, one beat per pixel,
// with in_data.frame_start set on the first pixel of a frame. A peak found at
// row r-1 is reported on out_valid/out_stall as column, row and raw value,
// caused by the beat carrying pixel (r, c). Beats that cause no peak give no
// output beat. Registers are written on cfg_valid/cfg_ready (always ready) by
// index: map width, map height, threshold.
// Path: a peak goes from its causing beat via the window stage registers into
// the output register. Throughput: one pixel per cycle while in_stall is low;
// the line stores are read/written once per beat, next column prefetched a beat ahead.
// Reset: synchronous, clears the counters, pipeline valids and registers to
// width 368, height 368, threshold 1638. Row stores are not cleared.
// Back-pressure: while out_stall holds a waiting peak and the window stage also
// holds a peak, in_stall is raised; otherwise pixels keep flowing.
module heatmap_local_peak_finder_top #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  hlpf_pkg::hlpf_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output hlpf_pkg::hlpf_out_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hlpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hlpf_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hlpf_pkg::*;

  localparam int CNT_W = $clog2(MAX_WIDTH);
  localparam int CMP_W = (CNT_W + 1 > DIM_W) ? CNT_W + 1 : DIM_W;

  logic [DIM_W-1:0] map_width_r;
  logic [DIM_W-1:0] map_height_r;
  value_t           threshold_r;

  logic [CNT_W-1:0] col_r, col_nxt, col_cur;
  logic [ROW_W-1:0] row_r, row_nxt, row_cur;

  logic [CMP_W-1:0] w_eff, col_ext;
  logic [DIM_W-1:0] h_eff, row_ext;
  logic             last_col, in_window;

  logic             in_accept;
  logic             s1_v_r, s1_v_nxt;
  value_t           s1_down_r;
  logic             s1_win_r;
  logic [COL_OUT_W-1:0] s1_col_r;
  logic [ROW_W-1:0] s1_row_r;

  value_t           center, left, up, right, raw_above;
  hlpf_win_t        win;
  logic             s1_peak, out_room, s1_adv;

  logic             out_valid_r, out_valid_nxt;
  hlpf_out_t        out_data_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= MAP_WIDTH_RST;
      map_height_r <= MAP_HEIGHT_RST;
      threshold_r  <= THRESHOLD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  map_width_r  <= cfg_data[DIM_W-1:0];
        CFG_MAP_HEIGHT: map_height_r <= cfg_data[DIM_W-1:0];
        CFG_THRESHOLD:  threshold_r  <= value_t'(cfg_data[VALUE_BITS-1:0]);
        default: ;
      endcase
    end
  end

  // saturated frame size
  always_comb begin
    w_eff = CMP_W'(map_width_r);
    if (w_eff < CMP_W'(MIN_DIM)) begin
      w_eff = CMP_W'(MIN_DIM);
    end else if (w_eff > CMP_W'(MAX_WIDTH)) begin
      w_eff = CMP_W'(MAX_WIDTH);
    end
    h_eff = map_height_r;
    if (h_eff < MIN_DIM) begin
      h_eff = MIN_DIM;
    end else if (h_eff > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end
  end

  // position of the arriving pixel and the next one
  always_comb begin
    col_cur  = in_data.frame_start ? '0 : col_r;
    row_cur  = in_data.frame_start ? '0 : row_r;
    col_ext  = CMP_W'(col_cur);
    row_ext  = DIM_W'(row_cur);
    last_col = col_ext >= (w_eff - CMP_W'(1));
    in_window = (row_ext >= DIM_W'(2)) && (row_ext <= (h_eff - DIM_W'(1))) &&
                (col_ext >= CMP_W'(1)) && (col_ext <= (w_eff - CMP_W'(2)));
    if (last_col) begin
      col_nxt = '0;
      row_nxt = (row_ext >= (h_eff - DIM_W'(1))) ? '0 : row_cur + ROW_W'(1);
    end else begin
      col_nxt = col_cur + CNT_W'(1);
      row_nxt = row_cur;
    end
  end

  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  hlpf_line_buf #(
    .MAX_WIDTH (MAX_WIDTH),
    .ADDR_W    (CNT_W)
  ) u_line_buf (
    .clk         (clk),
    .accept      (in_accept),
    .cur_addr    (col_cur),
    .next_addr   (col_nxt),
    .wr_smoothed (in_data.smoothed_value),
    .wr_raw      (in_data.raw_value),
    .center      (center),
    .left        (left),
    .up          (up),
    .right       (right),
    .raw_above   (raw_above)
  );

  // window stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_down_r <= in_data.smoothed_value;
      s1_win_r  <= in_window;
      s1_col_r  <= col_ext[COL_OUT_W-1:0];
      s1_row_r  <= row_cur - ROW_W'(1);
    end
  end

  always_comb begin
    win.center = center;
    win.up     = up;
    win.down   = s1_down_r;
    win.left   = left;
    win.right  = right;
  end

  hlpf_peak_eval u_peak_eval (
    .win       (win),
    .threshold (threshold_r),
    .in_window (s1_win_r),
    .is_peak   (s1_peak)
  );

  // flow control: only a held peak against a blocked output stops the input
  assign out_room = !out_valid_r || !out_stall;
  assign s1_adv   = !(s1_v_r && s1_peak) || out_room;
  assign in_stall = !s1_adv;

  always_comb begin
    s1_v_nxt = in_accept || (s1_v_r && !s1_adv);
    if (s1_v_r && s1_peak && out_room) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (s1_v_r && s1_peak && out_room) begin
      out_data_r.peak_column <= s1_col_r;
      out_data_r.peak_row    <= s1_row_r;
      out_data_r.peak_value  <= raw_above;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hdl/hlpf_port_checker.sv */
// port-level checks of the heatmap local peak finder, bound to the top level
// depends on hlpf_pkg and heatmap_local_peak_finder_top_assert.svh
`include "heatmap_local_peak_finder_top_assert.svh"

module hlpf_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input hlpf_pkg::hlpf_out_t out_data
);
  import hlpf_pkg::*;

  // a stalled result beat stays put
  `HLPF_ASSERT_NXT(a_out_hold, !rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result beat changed under stall")

  // pixels of the first row and the first column are never reported
  `HLPF_ASSERT_IMP(a_no_border, !rst_n, out_valid, (out_data.peak_column != '0) && (out_data.peak_row != '0), "peak reported on frame border")

  // the input is only held back by a blocked result
  `HLPF_ASSERT_IMP(a_stall_cause, !rst_n, in_stall, out_valid && out_stall, "input stalled without output back-pressure")

  // reset empties the result register and frees the input
  `HLPF_ASSERT_NXT(a_reset_clear, 1'b0, !rst_n, !out_valid && !in_stall, "pipeline not empty after reset")

endmodule

bind heatmap_local_peak_finder_top hlpf_port_checker u_port_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
